// ----- src/sbt_pkg.sv -----
`timescale 1ns / 1ps

package sbt_pkg;

   localparam int POS_BITS     = 24;
   localparam int KW_MAX_CHARS = 6;
   localparam int KW_BITS      = 8 * KW_MAX_CHARS;
   localparam int RES_MAX      = 3;

   typedef logic [POS_BITS-1:0] pos_type;
   typedef logic [KW_BITS-1:0]  kw_type;

   localparam pos_type POS_MAX = {POS_BITS{1'b1}};

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_X     = 8'h78;
   localparam logic [7:0] CH_ZERO  = 8'h30;

   localparam kw_type KW_FN     = KW_BITS'(16'h666E);
   localparam kw_type KW_LET    = KW_BITS'(24'h6C6574);
   localparam kw_type KW_IF     = KW_BITS'(16'h6966);
   localparam kw_type KW_ELSE   = KW_BITS'(32'h656C7365);
   localparam kw_type KW_WHILE  = KW_BITS'(40'h7768696C65);
   localparam kw_type KW_RETURN = KW_BITS'(48'h72657475726E);

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_DEC,
      MODE_HEXP,
      MODE_HEX
   } scan_mode_type;

   typedef enum logic [4:0] {
      KIND_EOF     = 5'd0,
      KIND_IDENT   = 5'd1,
      KIND_NUMBER  = 5'd2,
      KIND_FN      = 5'd3,
      KIND_LET     = 5'd4,
      KIND_IF      = 5'd5,
      KIND_ELSE    = 5'd6,
      KIND_WHILE   = 5'd7,
      KIND_RETURN  = 5'd8,
      KIND_LPAREN  = 5'd9,
      KIND_RPAREN  = 5'd10,
      KIND_LBRACE  = 5'd11,
      KIND_RBRACE  = 5'd12,
      KIND_COMMA   = 5'd13,
      KIND_PLUS    = 5'd14,
      KIND_MINUS   = 5'd15,
      KIND_STAR    = 5'd16,
      KIND_SLASH   = 5'd17,
      KIND_PERCENT = 5'd18,
      KIND_SEMI    = 5'd19,
      KIND_EQUAL   = 5'd20
   } token_kind_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       byte_present;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      token_kind_type token_kind;
      logic [63:0]    number_value;
      pos_type        start_offset;
      pos_type        token_length;
      pos_type        line_number;
      pos_type        column_number;
      logic           final_token;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } tok_type;

   function automatic pos_type sat_inc(input pos_type v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   // 16 marks a byte that is not a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd16;
      if (is_dec(c)) begin
         d = c - CH_ZERO;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = c - 8'h57;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = c - 8'h37;
      end
      return d[4:0];
   endfunction

   function automatic token_kind_type punct_kind(input logic [7:0] c);
      token_kind_type k;
      unique case (c)
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h7B:   k = KIND_LBRACE;
         8'h7D:   k = KIND_RBRACE;
         8'h2C:   k = KIND_COMMA;
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h25:   k = KIND_PERCENT;
         8'h3B:   k = KIND_SEMI;
         8'h3D:   k = KIND_EQUAL;
         default: k = KIND_EOF;
      endcase
      return k;
   endfunction

   function automatic token_kind_type keyword_kind(input kw_type kbuf, input pos_type cnt);
      token_kind_type k;
      k = KIND_IDENT;
      priority if (cnt > pos_type'(KW_MAX_CHARS)) begin
         k = KIND_IDENT;
      end else if (cnt == pos_type'(2) && kbuf == KW_FN) begin
         k = KIND_FN;
      end else if (cnt == pos_type'(3) && kbuf == KW_LET) begin
         k = KIND_LET;
      end else if (cnt == pos_type'(2) && kbuf == KW_IF) begin
         k = KIND_IF;
      end else if (cnt == pos_type'(4) && kbuf == KW_ELSE) begin
         k = KIND_ELSE;
      end else if (cnt == pos_type'(5) && kbuf == KW_WHILE) begin
         k = KIND_WHILE;
      end else if (cnt == pos_type'(6) && kbuf == KW_RETURN) begin
         k = KIND_RETURN;
      end else begin
         k = KIND_IDENT;
      end
      return k;
   endfunction

   // token left open by the scanner, placed at the held start position
   function automatic tok_type close_tok(
      input scan_mode_type mode,
      input logic          pz,
      input logic          ps,
      input kw_type        kbuf,
      input pos_type       cnt,
      input logic [63:0]   acc,
      input pos_type       s_off,
      input pos_type       s_line,
      input pos_type       s_col
   );
      tok_type t;
      t = '0;
      t.data.start_offset  = s_off;
      t.data.line_number   = s_line;
      t.data.column_number = s_col;
      priority if (ps) begin
         t.valid             = 1'b1;
         t.data.token_kind   = KIND_SLASH;
         t.data.token_length = pos_type'(1);
      end else if (pz) begin
         t.valid             = 1'b1;
         t.data.token_kind   = KIND_NUMBER;
         t.data.token_length = pos_type'(1);
      end else if (mode == MODE_IDENT) begin
         t.valid             = 1'b1;
         t.data.token_kind   = keyword_kind(kbuf, cnt);
         t.data.token_length = cnt;
      end else if (mode == MODE_DEC || mode == MODE_HEX) begin
         t.valid             = 1'b1;
         t.data.token_kind   = KIND_NUMBER;
         t.data.number_value = acc;
         t.data.token_length = cnt;
      end else begin
         t.valid = 1'b0;
      end
      return t;
   endfunction

endpackage

// ----- src/source_byte_tokenizer_unit.sv -----
`timescale 1ns / 1ps

// Streaming tokenizer: one source byte per request, tokens out one per response.
// Request channel (req_valid/req_stall/req_data): char_byte with byte_present, and
// end_of_source on the last request of a stream. An end-only request carries
// byte_present low. The end request flushes any open token and adds an eof token
// with final_token set; the scanner then returns to its reset state.
// Response channel (rsp_valid/rsp_stall/rsp_data): one token per transfer, in
// source order. A request yields zero to three tokens.
// The first token of an accepted request is scanned from the registered request and
// is on rsp_data as soon as it is written, when the queue is empty.
// Throughput: one request per cycle while req_stall is low; the scan state updates in
// the cycle after acceptance, and its tokens go into an 8-entry result queue read out
// one per cycle while rsp_stall is low. req_stall rises when the queue holds more
// than two tokens while a request is in flight, or more than five otherwise, so a
// stalled receiver backs up into the request side after a few tokens without losing any.
// Reset (synchronous, active high) empties the queue and clears the scanner:
// line 1, column 0, offset 0.

module source_byte_tokenizer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sbt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sbt_pkg::rsp_type rsp_data
);

   localparam int DEPTH     = 8;
   localparam int PTR_BITS  = $clog2(DEPTH);
   localparam int CNT_BITS  = PTR_BITS + 1;

   logic                  req_accept;
   logic                  pop;

   logic                  item_valid_ff;
   sbt_pkg::req_type      item_ff;

   sbt_pkg::scan_mode_type mode_ff, mode_in;
   sbt_pkg::kw_type       kbuf_ff, kbuf_in;
   sbt_pkg::pos_type      cnt_ff, cnt_in;
   logic [63:0]           acc_ff, acc_in;
   logic                  pz_ff, pz_in;
   logic                  ps_ff, ps_in;
   logic                  cmt_ff, cmt_in;
   sbt_pkg::pos_type      line_ff, line_in;
   sbt_pkg::pos_type      col_ff, col_in;
   sbt_pkg::pos_type      off_ff, off_in;
   sbt_pkg::pos_type      s_off_ff, s_off_in;
   sbt_pkg::pos_type      s_line_ff, s_line_in;
   sbt_pkg::pos_type      s_col_ff, s_col_in;

   sbt_pkg::tok_type      tok_a, tok_b, tok_c, tok_d;
   sbt_pkg::rsp_type      res_w [sbt_pkg::RES_MAX];
   logic [1:0]            push_n;

   sbt_pkg::rsp_type      fifo_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (count_ff != '0);
   assign rsp_data   = fifo_ff[rd_ptr_ff];
   assign pop        = rsp_valid && !rsp_stall;
   assign req_stall  = item_valid_ff ?
                       (count_ff > CNT_BITS'(DEPTH - 2 * sbt_pkg::RES_MAX)) :
                       (count_ff > CNT_BITS'(DEPTH - sbt_pkg::RES_MAX));

   // scanner step for the registered request
   always_comb begin
      logic [7:0]              c;
      logic [4:0]              hv;
      sbt_pkg::token_kind_type pk;

      c  = item_ff.char_byte;
      hv = sbt_pkg::hex_val(c);
      pk = sbt_pkg::punct_kind(c);

      mode_in   = mode_ff;
      kbuf_in   = kbuf_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      pz_in     = pz_ff;
      ps_in     = ps_ff;
      cmt_in    = cmt_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      off_in    = off_ff;
      s_off_in  = s_off_ff;
      s_line_in = s_line_ff;
      s_col_in  = s_col_ff;
      tok_a     = '0;
      tok_b     = '0;
      tok_c     = '0;
      tok_d     = '0;

      if (item_valid_ff && item_ff.byte_present) begin
         priority if (cmt_ff) begin
            if (c == sbt_pkg::CH_NL) begin
               cmt_in = 1'b0;
            end
         end else if (ps_ff && c == sbt_pkg::CH_SLASH) begin
            ps_in  = 1'b0;
            cmt_in = 1'b1;
         end else if (pz_ff && c == sbt_pkg::CH_X) begin
            pz_in   = 1'b0;
            mode_in = sbt_pkg::MODE_HEXP;
            cnt_in  = sbt_pkg::pos_type'(2);
            acc_in  = '0;
         end else if (mode_ff == sbt_pkg::MODE_IDENT &&
                      (sbt_pkg::is_letter(c) || sbt_pkg::is_dec(c))) begin
            if (cnt_ff < sbt_pkg::pos_type'(sbt_pkg::KW_MAX_CHARS)) begin
               kbuf_in = {kbuf_ff[sbt_pkg::KW_BITS-9:0], c};
            end
            cnt_in = sbt_pkg::sat_inc(cnt_ff);
         end else if (mode_ff == sbt_pkg::MODE_DEC && sbt_pkg::is_dec(c)) begin
            acc_in = (acc_ff << 3) + (acc_ff << 1) + 64'(hv[3:0]);
            cnt_in = sbt_pkg::sat_inc(cnt_ff);
         end else if ((mode_ff == sbt_pkg::MODE_HEXP || mode_ff == sbt_pkg::MODE_HEX) &&
                      !hv[4]) begin
            acc_in  = {acc_ff[59:0], hv[3:0]};
            cnt_in  = sbt_pkg::sat_inc(cnt_ff);
            mode_in = sbt_pkg::MODE_HEX;
         end else begin
            tok_a = sbt_pkg::close_tok(mode_ff, pz_ff, ps_ff, kbuf_ff, cnt_ff, acc_ff,
                                       s_off_ff, s_line_ff, s_col_ff);
            mode_in = sbt_pkg::MODE_IDLE;
            pz_in   = 1'b0;
            ps_in   = 1'b0;
            kbuf_in = '0;
            acc_in  = '0;
            cnt_in  = '0;
            priority if (sbt_pkg::is_letter(c)) begin
               s_off_in  = off_ff;
               s_line_in = line_ff;
               s_col_in  = col_ff;
               mode_in   = sbt_pkg::MODE_IDENT;
               kbuf_in   = sbt_pkg::KW_BITS'(c);
               cnt_in    = sbt_pkg::pos_type'(1);
            end else if (c == sbt_pkg::CH_ZERO) begin
               s_off_in  = off_ff;
               s_line_in = line_ff;
               s_col_in  = col_ff;
               pz_in     = 1'b1;
            end else if (sbt_pkg::is_dec(c)) begin
               s_off_in  = off_ff;
               s_line_in = line_ff;
               s_col_in  = col_ff;
               mode_in   = sbt_pkg::MODE_DEC;
               acc_in    = 64'(hv[3:0]);
               cnt_in    = sbt_pkg::pos_type'(1);
            end else if (c == sbt_pkg::CH_SLASH) begin
               s_off_in  = off_ff;
               s_line_in = line_ff;
               s_col_in  = col_ff;
               ps_in     = 1'b1;
            end else begin
               if (pk != sbt_pkg::KIND_EOF) begin
                  tok_b.valid              = 1'b1;
                  tok_b.data.token_kind    = pk;
                  tok_b.data.start_offset  = off_ff;
                  tok_b.data.token_length  = sbt_pkg::pos_type'(1);
                  tok_b.data.line_number   = line_ff;
                  tok_b.data.column_number = col_ff;
               end
            end
         end
         off_in = sbt_pkg::sat_inc(off_ff);
         if (c == sbt_pkg::CH_NL) begin
            line_in = sbt_pkg::sat_inc(line_ff);
            col_in  = '0;
         end else begin
            col_in = sbt_pkg::sat_inc(col_ff);
         end
      end

      if (item_valid_ff && item_ff.end_of_source) begin
         tok_c = sbt_pkg::close_tok(mode_in, pz_in, ps_in, kbuf_in, cnt_in, acc_in,
                                    s_off_in, s_line_in, s_col_in);
         tok_d.valid              = 1'b1;
         tok_d.data.token_kind    = sbt_pkg::KIND_EOF;
         tok_d.data.start_offset  = off_in;
         tok_d.data.line_number   = line_in;
         tok_d.data.column_number = col_in;
         tok_d.data.final_token   = 1'b1;
         mode_in   = sbt_pkg::MODE_IDLE;
         kbuf_in   = '0;
         cnt_in    = '0;
         acc_in    = '0;
         pz_in     = 1'b0;
         ps_in     = 1'b0;
         cmt_in    = 1'b0;
         line_in   = sbt_pkg::pos_type'(1);
         col_in    = '0;
         off_in    = '0;
         s_off_in  = '0;
         s_line_in = sbt_pkg::pos_type'(1);
         s_col_in  = '0;
      end
   end

   // pack the valid tokens in source order
   always_comb begin
      sbt_pkg::tok_type toks [4];
      logic [1:0]       n;

      toks[0] = tok_a;
      toks[1] = tok_b;
      toks[2] = tok_c;
      toks[3] = tok_d;
      n       = '0;
      for (int i = 0; i < sbt_pkg::RES_MAX; i++) begin
         res_w[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         if (toks[i].valid && n < 2'(sbt_pkg::RES_MAX)) begin
            res_w[n] = toks[i].data;
            n        = n + 2'd1;
         end
      end
      push_n = n;
   end

   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign count_in  = count_ff + CNT_BITS'(push_n) - CNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
         mode_ff       <= sbt_pkg::MODE_IDLE;
         kbuf_ff       <= '0;
         cnt_ff        <= '0;
         acc_ff        <= '0;
         pz_ff         <= 1'b0;
         ps_ff         <= 1'b0;
         cmt_ff        <= 1'b0;
         line_ff       <= sbt_pkg::pos_type'(1);
         col_ff        <= '0;
         off_ff        <= '0;
         s_off_ff      <= '0;
         s_line_ff     <= sbt_pkg::pos_type'(1);
         s_col_ff      <= '0;
      end else begin
         item_valid_ff <= req_accept;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         count_ff      <= count_in;
         mode_ff       <= mode_in;
         kbuf_ff       <= kbuf_in;
         cnt_ff        <= cnt_in;
         acc_ff        <= acc_in;
         pz_ff         <= pz_in;
         ps_ff         <= ps_in;
         cmt_ff        <= cmt_in;
         line_ff       <= line_in;
         col_ff        <= col_in;
         off_ff        <= off_in;
         s_off_ff      <= s_off_in;
         s_line_ff     <= s_line_in;
         s_col_ff      <= s_col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_data;
      end
      for (int k = 0; k < sbt_pkg::RES_MAX; k++) begin
         if (2'(k) < push_n) begin
            fifo_ff[wr_ptr_ff + PTR_BITS'(k)] <= res_w[k];
         end
      end
   end

`ifndef SYNTH
   a_queue_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("result queue overflow");

   a_pending_alone : assert property (@(posedge clock) disable iff (reset)
      (ps_ff || pz_ff) |-> (!(ps_ff && pz_ff) && mode_ff == sbt_pkg::MODE_IDLE))
      else $error("pending slash or zero alongside an open token");

   a_end_restarts : assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && item_ff.end_of_source) |=>
         (mode_ff == sbt_pkg::MODE_IDLE && !cmt_ff && !ps_ff && !pz_ff &&
          off_ff == '0 && line_ff == sbt_pkg::pos_type'(1)))
      else $error("scanner not restarted after end of source");
`endif

endmodule
